[rtl/qhe_pkg.sv]
`timescale 1ns / 1ps
package qhe_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SELECT_W  = 8;
	localparam int BINCNT_W  = 9;
	localparam int LEVELS_W  = 10;
	localparam int RANGE_W   = 17;
	localparam int NUM_W     = SAMPLE_W + LEVELS_W;
	localparam int VALUE_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINS  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_MODIFY,
		ST_RESP
	} state_t;

endpackage

[rtl/qhe_ram.sv]
`timescale 1ns / 1ps
module qhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/qhe_div.sv]
`timescale 1ns / 1ps
module qhe_div #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// shift one numerator bit into the partial remainder
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quot  <= {quot[NUM_W-2:0], fits};
		end
	end

endmodule

[rtl/quantized_histogram_engine.sv]
`timescale 1ns / 1ps
// Histogram of a sample stream over BINS saturating counters held in one
// synchronous RAM. One beat in on s_* gives one beat out on m_*. After reset
// the block clears the whole RAM before it takes its first beat;
// configuration writes are taken at any time. An add runs through a
// bit-serial divider (one quotient bit per cycle) for the bin index and then
// a read-modify-write of the RAM; a read or clear reads the selected bin
// and a clear zeroes it. An out-of-range add, an unused function code or
// a bin_select of BINS or more goes straight to the response. No new beat
// is taken before the last is done, yet one is taken while a result waits on m_*.
module quantized_histogram_engine #(
	parameter int BINS        = 256,
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [23:0]                   s_tdata,   // sample, bin_select
	input  logic [1:0]                    s_tuser,   // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,   // bin_index, bin_value
	output logic [0:0]                    m_tuser,   // out_of_range
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qhe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qhe_pkg::CFG_DAT_W-1:0] cfg_data
);

	import qhe_pkg::*;

	localparam int IDX_W = $clog2(BINS);
	localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] lower_q, upper_q;
	logic [BINCNT_W-1:0] bincnt_q;

	logic [1:0]            func_q;
	logic [SELECT_W-1:0]   sel_q;
	logic [IDX_W-1:0]      addr_q;
	logic [IDX_W-1:0]      clr_q;
	logic [SELECT_W-1:0]   res_idx_q;
	logic [VALUE_W-1:0]    res_val_q;
	logic                  res_oor_q;
	logic [NUM_W-1:0]      num_q;
	logic                  div_start_q;

	logic [1:0]            in_func;
	logic [SAMPLE_W-1:0]   in_sample;
	logic [SELECT_W-1:0]   in_sel;
	logic                  accept;
	logic                  oor;
	logic [RANGE_W-1:0]    range_w;
	logic [RANGE_W-1:0]    lv_a, lv_b, lv_c;
	logic [LEVELS_W-1:0]   levels;
	logic                  sel_ok;

	logic                  div_done;
	logic [NUM_W-1:0]      quot;
	logic [IDX_W-1:0]      quot_idx;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, cnt_inc;
	logic [63:0]           val_ext;

	assign in_func   = s_tuser;
	assign in_sample = s_tdata[15:0] & SMASK;
	assign in_sel    = s_tdata[23:16];
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign oor = (upper_q < lower_q) || (in_sample < lower_q) || (in_sample > upper_q);
	assign range_w = RANGE_W'(upper_q) - RANGE_W'(lower_q) + 1'b1;
	assign lv_a = (bincnt_q == '0) ? RANGE_W'(1) : RANGE_W'(bincnt_q);
	assign lv_b = (lv_a > RANGE_W'(BINS)) ? RANGE_W'(BINS) : lv_a;
	assign lv_c = (lv_b > range_w) ? range_w : lv_b;
	assign levels = LEVELS_W'(lv_c);
	assign sel_ok = RANGE_W'(in_sel) < RANGE_W'(BINS);

	assign quot_idx = (quot >= NUM_W'(BINS)) ? IDX_W'(BINS - 1) : IDX_W'(quot);

	assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

	qhe_div #(
		.NUM_W (NUM_W),
		.DEN_W (RANGE_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (range_w),
		.done   (div_done),
		.quot   (quot)
	);

	qhe_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		val_ext   = 64'(ram_rdata);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == IDX_W'(BINS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_ADD) begin
						state_d = oor ? ST_RESP : ST_DIV;
					end else if ((in_func == FUNC_READ || in_func == FUNC_CLEAR) && sel_ok) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				if (func_q == FUNC_ADD) begin
					ram_we    = 1'b1;
					ram_wdata = cnt_inc;
					val_ext   = 64'(cnt_inc);
				end else if (func_q == FUNC_CLEAR) begin
					ram_we = 1'b1;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!m_tvalid || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			lower_q     <= '0;
			upper_q     <= 16'hFFFF;
			bincnt_q    <= 9'd256;
			m_tvalid    <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			div_start_q <= accept && (in_func == FUNC_ADD) && !oor;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LOWER: lower_q  <= cfg_data;
					REG_UPPER: upper_q  <= cfg_data;
					REG_BINS:  bincnt_q <= cfg_data[BINCNT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_RESP && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= in_func;
			sel_q     <= in_sel;
			addr_q    <= IDX_W'(in_sel);
			num_q     <= NUM_W'((in_sample - lower_q) * levels);
			res_idx_q <= (in_func == FUNC_READ || in_func == FUNC_CLEAR) ? in_sel : '0;
			res_val_q <= '0;
			res_oor_q <= (in_func == FUNC_ADD) && oor;
		end
		if (state_q == ST_DIV && div_done) begin
			addr_q <= quot_idx;
		end
		if (state_q == ST_MODIFY) begin
			res_val_q <= val_ext[VALUE_W-1:0];
			res_idx_q <= (func_q == FUNC_ADD) ? SELECT_W'(addr_q) : sel_q;
		end
		if (state_q == ST_RESP && (!m_tvalid || m_tready)) begin
			m_tdata <= {res_val_q, res_idx_q};
			m_tuser <= res_oor_q;
		end
	end

endmodule
